FILE: sv/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg: shared definitions for the grid event histogram
// Grid limits, counter width and register indexes for the histogram and
// its cell counter memory.
// ----------------------------------------------------------------------------
package gha_pkg;

	localparam int MAX_ROWS   = 16;
	localparam int MAX_COLS   = 16;
	localparam int COUNT_BITS = 16;

	localparam int ROW_BITS   = $clog2(MAX_ROWS);
	localparam int COL_BITS   = $clog2(MAX_COLS);
	localparam int CELLS      = MAX_ROWS * MAX_COLS;
	localparam int ADDR_BITS  = $clog2(CELLS);
	localparam int SIZE_BITS  = 5;
	localparam int NOTE_BITS  = 7;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

	localparam logic [SIZE_BITS-1:0] ROWS_LIMIT = SIZE_BITS'(MAX_ROWS);
	localparam logic [SIZE_BITS-1:0] COLS_LIMIT = SIZE_BITS'(MAX_COLS);

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COLS_IN_USE = 1'd1;

	// Row-major cell address
	function automatic logic [ADDR_BITS-1:0] cell_addr(
		input logic [ROW_BITS-1:0] row,
		input logic [COL_BITS-1:0] col
	);
		cell_addr = ADDR_BITS'(row * MAX_COLS) + ADDR_BITS'(col);
	endfunction

endpackage

FILE: sv/grid_event_histogram_argmax_unit.sv
// ----------------------------------------------------------------------------
// grid_event_histogram_argmax_unit: per-cell spike histogram with argmax
// Counts spike events per grid cell and reports the busiest cell.
// ----------------------------------------------------------------------------
// Events arrive on the in_valid/in_ready channel as (event_row, event_col).
// An event inside the grid set by rows_in_use and cols_in_use bumps that
// cell's saturating counter; every event, inside or not, produces one result
// on the out_valid/out_ready channel: accepted, plus the note and count of the
// first cell (row-major) holding the highest count.
// The counter memory is read on the input transfer; the read-modify-write and
// winner update happen in the second stage, which loads the output register.
// One event per cycle is sustained while out_ready stays high; the single memory
// read port and the write-back forwarding path set that figure.
// Reset clears the winner and marks every cell as empty through per-cell valid
// flags, so events are taken right after reset. When the receiver stalls, the
// output register holds its result and the second stage can still take one more
// event; after that in_ready drops. Grid sizes must be written on the cfg port
// while no event is in flight; the user must ensure it; the block does not check.
// ----------------------------------------------------------------------------
module grid_event_histogram_argmax_unit
	import gha_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SIZE_BITS-1:0]    cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ROW_BITS-1:0]     event_row,
	input  logic [COL_BITS-1:0]     event_col,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    accepted,
	output logic [NOTE_BITS-1:0]    winning_note,
	output logic [COUNT_BITS-1:0]   winning_count
);

	logic [SIZE_BITS-1:0]  rows_in_use_q, cols_in_use_q;
	logic [SIZE_BITS-1:0]  rows_eff, cols_eff;

	logic                  in_xfer, s1_adv, s1_fire;
	logic                  in_grid;
	logic [ADDR_BITS-1:0]  rd_addr;

	logic                  s1_valid_q;
	logic                  ok_s1;
	logic [ROW_BITS-1:0]   row_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic [ADDR_BITS-1:0]  addr_s1;
	logic                  rd_valid_s1;
	logic [COUNT_BITS-1:0] rd_data_s1;

	logic                  cell_valid_q [CELLS];
	logic                  last_wr_valid_q;
	logic [ADDR_BITS-1:0]  last_wr_addr_q;
	logic [COUNT_BITS-1:0] last_wr_data_q;

	logic [COUNT_BITS-1:0] cur_count, new_count;
	logic                  ram_we;
	logic                  take_best;

	logic [COUNT_BITS-1:0] best_count_q;
	logic [ROW_BITS-1:0]   best_row_q;
	logic [COL_BITS-1:0]   best_col_q;
	logic [COUNT_BITS-1:0] best_count_d;
	logic [ROW_BITS-1:0]   best_row_d;
	logic [COL_BITS-1:0]   best_col_d;
	logic [ROW_BITS+SIZE_BITS-1:0] note_full;
	logic [NOTE_BITS-1:0]  note_d;

	logic                  out_valid_q;
	logic                  accepted_q;
	logic [NOTE_BITS-1:0]  note_q;
	logic [COUNT_BITS-1:0] count_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= ROWS_LIMIT;
			cols_in_use_q <= COLS_LIMIT;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROWS_IN_USE) begin
				rows_in_use_q <= cfg_data;
			end else if (cfg_index == CFG_COLS_IN_USE) begin
				cols_in_use_q <= cfg_data;
			end
		end
	end

	assign rows_eff = (rows_in_use_q > ROWS_LIMIT) ? ROWS_LIMIT : rows_in_use_q;
	assign cols_eff = (cols_in_use_q > COLS_LIMIT) ? COLS_LIMIT : cols_in_use_q;

	// Handshake: the second stage moves when the output register is free or
	// being emptied; a new event enters whenever the second stage moves or is empty.
	assign s1_adv   = !out_valid_q || out_ready;
	assign s1_fire  = s1_valid_q && s1_adv;
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_xfer  = in_valid && in_ready;

	assign in_grid = (SIZE_BITS'(event_row) < rows_eff) && (SIZE_BITS'(event_col) < cols_eff);
	assign rd_addr = cell_addr(event_row, event_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ok_s1       <= in_grid;
			row_s1      <= event_row;
			col_s1      <= event_col;
			addr_s1     <= rd_addr;
			rd_valid_s1 <= cell_valid_q[rd_addr];
		end
	end

	gha_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (CELLS)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (new_count),
		.re    (in_xfer),
		.raddr (rd_addr),
		.rdata (rd_data_s1)
	);

	// The most recent write is forwarded, since the memory reads old data when
	// the event ahead writes the same cell in the same cycle.
	always_comb begin
		if (last_wr_valid_q && (last_wr_addr_q == addr_s1)) begin
			cur_count = last_wr_data_q;
		end else if (rd_valid_s1) begin
			cur_count = rd_data_s1;
		end else begin
			cur_count = '0;
		end
		new_count = (cur_count == COUNT_TOP) ? cur_count : cur_count + 1'b1;
	end

	assign ram_we = s1_fire && ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				cell_valid_q[i] <= 1'b0;
			end
			last_wr_valid_q <= 1'b0;
		end else if (ram_we) begin
			cell_valid_q[addr_s1] <= 1'b1;
			last_wr_valid_q       <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			last_wr_addr_q <= addr_s1;
			last_wr_data_q <= new_count;
		end
	end

	// Running maximum; ties go to the cell with the lower row-major address.
	assign take_best = ram_we && ((new_count > best_count_q) ||
		((new_count == best_count_q) && (addr_s1 < cell_addr(best_row_q, best_col_q))));

	always_comb begin
		if (take_best) begin
			best_count_d = new_count;
			best_row_d   = row_s1;
			best_col_d   = col_s1;
		end else begin
			best_count_d = best_count_q;
			best_row_d   = best_row_q;
			best_col_d   = best_col_q;
		end
		// The full row-major index is formed first; its low bits are the note.
		note_full = (ROW_BITS+SIZE_BITS)'(best_row_d) * (ROW_BITS+SIZE_BITS)'(cols_eff) +
			(ROW_BITS+SIZE_BITS)'(best_col_d);
		note_d = note_full[NOTE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_count_q <= '0;
			best_row_q   <= '0;
			best_col_q   <= '0;
		end else if (take_best) begin
			best_count_q <= best_count_d;
			best_row_q   <= best_row_d;
			best_col_q   <= best_col_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			accepted_q <= ok_s1;
			note_q     <= note_d;
			count_q    <= best_count_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign winning_note  = note_q;
	assign winning_count = count_q;

	// The winning count can only grow.
	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		best_count_q >= $past(best_count_q))
		else $error("best count decreased");

	// A counted event leaves a winner at least as high as its own new count.
	a_best_covers_count: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> best_count_q >= $past(new_count))
		else $error("winner below a freshly counted cell");

	// With the second stage full and the output stalled, no event may enter.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !out_ready) |-> !in_ready)
		else $error("event taken while pipeline is full");

endmodule

FILE: sv/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module gha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sim/tb_grid_event_histogram_argmax_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_event_histogram_argmax_unit: self-checking bench for the histogram
// Drives spike events with random gaps and back-pressure, keeps its own copy
// of the cell counters and the running winner, and checks every result field
// against it. The bench covers grid edges, oversized and zero grid sizes,
// size changes after events and random traffic.
// ----------------------------------------------------------------------------
module tb_grid_event_histogram_argmax_unit;
	import gha_pkg::*;

	typedef struct packed {
		logic                  accepted;
		logic [NOTE_BITS-1:0]  note;
		logic [COUNT_BITS-1:0] count;
	} score_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [SIZE_BITS-1:0]    cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [ROW_BITS-1:0]     event_row;
	logic [COL_BITS-1:0]     event_col;
	logic                    out_valid;
	logic                    out_ready;
	logic                    accepted;
	logic [NOTE_BITS-1:0]    winning_note;
	logic [COUNT_BITS-1:0]   winning_count;

	// Shadow of the block: counters, winner and grid sizes.
	logic [COUNT_BITS-1:0] cell_tally [CELLS];
	logic [COUNT_BITS-1:0] lead_count;
	logic [ROW_BITS-1:0]   lead_row;
	logic [COL_BITS-1:0]   lead_col;
	logic [SIZE_BITS-1:0]  grid_rows;
	logic [SIZE_BITS-1:0]  grid_cols;

	score_t pending_scores [$];

	bit quiet;
	int sink_hold;
	int mismatches;
	int events_sent;
	int events_ignored;
	int results_seen;
	int size_writes;

	grid_event_histogram_argmax_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.event_row     (event_row),
		.event_col     (event_col),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.accepted      (accepted),
		.winning_note  (winning_note),
		.winning_count (winning_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int clip_size(input logic [SIZE_BITS-1:0] reg_value, input int limit);
		return (int'(reg_value) > limit) ? limit : int'(reg_value);
	endfunction

	// Counts one event and returns the winner that the block should report.
	function automatic score_t tally_event(input logic [ROW_BITS-1:0] row,
		input logic [COL_BITS-1:0] col);
		int     rows_eff;
		int     cols_eff;
		int     addr;
		score_t s;
		rows_eff = clip_size(grid_rows, MAX_ROWS);
		cols_eff = clip_size(grid_cols, MAX_COLS);
		s.accepted = (int'(row) < rows_eff) && (int'(col) < cols_eff);
		if (s.accepted) begin
			addr = int'(row) * MAX_COLS + int'(col);
			if (cell_tally[addr] != COUNT_TOP)
				cell_tally[addr] = cell_tally[addr] + 1'b1;
			// Row-major order is the order of the concatenated coordinates.
			if (cell_tally[addr] > lead_count ||
				(cell_tally[addr] == lead_count && {row, col} < {lead_row, lead_col})) begin
				lead_count = cell_tally[addr];
				lead_row   = row;
				lead_col   = col;
			end
		end
		s.note  = NOTE_BITS'((int'(lead_row) * cols_eff + int'(lead_col)) % 128);
		s.count = lead_count;
		return s;
	endfunction

	// Sender: called and left at a falling edge.
	task automatic send_event(input logic [ROW_BITS-1:0] row, input logic [COL_BITS-1:0] col);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		event_row <= row;
		event_col <= col;
		do @(posedge clk); while (!in_ready);
		pending_scores.push_back(tally_event(row, col));
		events_sent++;
		if (!pending_scores[$].accepted)
			events_ignored++;
		@(negedge clk);
	endtask

	task automatic hold_until_drained;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_scores.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_size(input logic [CFG_IDX_BITS-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= SIZE_BITS'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ROWS_IN_USE)
			grid_rows = SIZE_BITS'(value);
		else
			grid_cols = SIZE_BITS'(value);
		size_writes++;
	endtask

	task automatic set_grid(input int rows, input int cols);
		hold_until_drained;
		write_size(CFG_ROWS_IN_USE, rows);
		write_size(CFG_COLS_IN_USE, cols);
	endtask

	// Receiver: after each transfer it holds out_ready low for a randomly drawn stall.
	always @(negedge clk) begin
		if (quiet)
			sink_hold = 0;
		if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold = sink_hold - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		score_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			sink_hold = quiet ? 0 : $urandom_range(0, 6);
			if (pending_scores.size() == 0) begin
				$display("%0t: result with nothing expected, actual accepted %0d note %0d count %0d",
					$time, accepted, winning_note, winning_count);
				mismatches++;
			end else begin
				want = pending_scores.pop_front();
				if (accepted !== want.accepted) begin
					$display("%0t: accepted mismatch, expected %0d actual %0d",
						$time, want.accepted, accepted);
					mismatches++;
				end
				if (winning_note !== want.note) begin
					$display("%0t: winning_note mismatch, expected %0d actual %0d",
						$time, want.note, winning_note);
					mismatches++;
				end
				if (winning_count !== want.count) begin
					$display("%0t: winning_count mismatch, expected %0d actual %0d",
						$time, want.count, winning_count);
					mismatches++;
				end
			end
		end
	end

	// The first events run on the reset sizes of 16 by 16.
	task automatic test_reset_state;
		send_event(4'd15, 4'd15);
		// Equal count at an earlier cell takes over the lead.
		send_event(4'd0, 4'd0);
	endtask

	task automatic test_grid_edges;
		set_grid(3, 5);
		send_event(4'd2, 4'd4);
		send_event(4'd3, 4'd0);
		send_event(4'd0, 4'd5);
		send_event(4'd15, 4'd15);
		send_event(4'd2, 4'd4);
		send_event(4'd2, 4'd4);
	endtask

	task automatic test_oversize;
		set_grid(31, 31);
		send_event(4'd15, 4'd15);
		send_event(4'd15, 4'd0);
		set_grid(16, 17);
		send_event(4'd1, 4'd15);
	endtask

	task automatic test_zero_size;
		set_grid(0, 16);
		send_event(4'd0, 4'd0);
		set_grid(5, 0);
		send_event(4'd0, 4'd0);
	endtask

	// The lead is kept across a size change; only its note numbering moves.
	task automatic test_size_change;
		set_grid(5, 7);
		send_event(4'd15, 4'd15);
		send_event(4'd4, 4'd6);
		set_grid(16, 1);
		send_event(4'd0, 4'd3);
		send_event(4'd15, 4'd0);
	endtask

	task automatic test_random_traffic;
		int grid_list [9][2];
		int rows_eff;
		int cols_eff;
		int count;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		grid_list = '{'{16, 16}, '{1, 1}, '{2, 3}, '{31, 31}, '{17, 4},
			'{0, 9}, '{4, 16}, '{16, 2}, '{0, 0}};
		grid_list[8][0] = $urandom_range(1, 16);
		grid_list[8][1] = $urandom_range(1, 16);
		for (int p = 0; p < 9; p++) begin
			set_grid(grid_list[p][0], grid_list[p][1]);
			rows_eff = clip_size(grid_rows, MAX_ROWS);
			cols_eff = clip_size(grid_cols, MAX_COLS);
			count = (rows_eff == 0 || cols_eff == 0) ? 30 : 88;
			quiet = (p == 6);
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 9) < 8 && rows_eff > 0 && cols_eff > 0) begin
					row = ROW_BITS'($urandom_range(0, rows_eff - 1));
					col = COL_BITS'($urandom_range(0, cols_eff - 1));
				end else begin
					row = ROW_BITS'($urandom);
					col = COL_BITS'($urandom);
				end
				send_event(row, col);
				if (p == 2 && i == count / 2)
					hold_until_drained;
			end
			quiet = 1'b0;
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_ROWS_IN_USE;
		cfg_data  = '0;
		in_valid  = 1'b0;
		event_row = '0;
		event_col = '0;
		out_ready = 1'b0;
		quiet     = 1'b0;
		sink_hold = 0;
		mismatches = 0;
		events_sent = 0;
		events_ignored = 0;
		results_seen = 0;
		size_writes = 0;
		foreach (cell_tally[i])
			cell_tally[i] = '0;
		lead_count = '0;
		lead_row   = '0;
		lead_col   = '0;
		grid_rows  = ROWS_LIMIT;
		grid_cols  = COLS_LIMIT;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state;
		test_grid_edges;
		test_oversize;
		test_zero_size;
		test_size_change;
		test_random_traffic;

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_scores.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d events (%0d outside the grid), checked %0d results, %0d size writes.",
			events_sent, events_ignored, results_seen, size_writes);
		$display("Covered grid edges, oversized and zero sizes, resizing and tie-breaks.");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Run did not complete in time.");
		$display("CHECK FAILED");
		$finish;
	end

endmodule
